@@ hw/rtl/wpla_pkg.sv @@
package wpla_pkg;

   // Geometry limits
   localparam int MAX_ROI_SIDE   = 1024;
   localparam int MAX_FRAME_SIDE = 4096;
   localparam int CORDIC_STEPS   = 16;

   // Moment widths follow from the largest region side
   localparam int COORD_W = $clog2(MAX_ROI_SIDE);
   localparam int COUNT_W = 2 * COORD_W + 1;
   localparam int SUM_W   = 3 * COORD_W;
   localparam int SQ_W    = 4 * COORD_W;
   localparam int SQ_LO_W = SQ_W / 2;
   localparam int MUL_W   = SUM_W;
   localparam int ACC_W   = 64;

   // Fixed field widths
   localparam int LEVEL_W     = 8;
   localparam int POS_W       = 12;
   localparam int ROI_SIDE_W  = 11;
   localparam int FRAME_CFG_W = 13;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   // Angle arithmetic
   localparam int ROT_W    = 33;
   localparam int Z_W      = 26;
   localparam int ATAN_W   = 22;
   localparam int STEP_W   = 5;
   localparam int ANGLE_W  = 17;
   localparam int BEND_W   = 17;
   localparam int ANGLE_LIMIT = 23040;
   localparam int BEND_LIMIT  = 46080;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ROI_SIDE * MAX_ROI_SIDE);

   typedef enum logic [1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_ROI_LEFT      = 3'd0,
      REG_ROI_TOP       = 3'd1,
      REG_ROI_WIDTH     = 3'd2,
      REG_ROI_HEIGHT    = 3'd3,
      REG_CALIB_LEVEL   = 3'd4,
      REG_MEASURE_LEVEL = 3'd5,
      REG_FRAME_WIDTH   = 3'd6,
      REG_FRAME_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [POS_W-1:0]   col;
      logic [POS_W-1:0]   row;
      logic               frame_end;
      logic               calibrate;
   } req_type;

   typedef struct packed {
      logic signed [BEND_W-1:0] bend_angle;
      logic signed [15:0]       baseline_angle_out;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]       roi_left;
      logic [POS_W-1:0]       roi_top;
      logic [ROI_SIDE_W-1:0]  roi_width;
      logic [ROI_SIDE_W-1:0]  roi_height;
      logic [LEVEL_W-1:0]     calib_level;
      logic [LEVEL_W-1:0]     measure_level;
      logic [FRAME_CFG_W-1:0] frame_width;
      logic [FRAME_CFG_W-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum_x;
      logic [SUM_W-1:0]   sum_y;
      logic [SQ_W-1:0]    sum_xx;
      logic [SQ_W-1:0]    sum_yy;
      logic [SQ_W-1:0]    sum_xy;
   } moment_type;

   // Clip a region side to the largest supported side
   function automatic logic [ROI_SIDE_W-1:0] sat_roi(input logic [ROI_SIDE_W-1:0] v);
      sat_roi = (v > ROI_SIDE_W'(MAX_ROI_SIDE)) ? ROI_SIDE_W'(MAX_ROI_SIDE) : v;
   endfunction

   // Clip a frame side to the largest supported side
   function automatic logic [FRAME_CFG_W-1:0] sat_frame(input logic [FRAME_CFG_W-1:0] v);
      sat_frame = (v > FRAME_CFG_W'(MAX_FRAME_SIDE)) ? FRAME_CFG_W'(MAX_FRAME_SIDE) : v;
   endfunction

   // Rounded atan(2^-i) in degrees * 65536
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:    atan_entry = 22'd2949120;
         5'd1:    atan_entry = 22'd1740967;
         5'd2:    atan_entry = 22'd919879;
         5'd3:    atan_entry = 22'd466945;
         5'd4:    atan_entry = 22'd234379;
         5'd5:    atan_entry = 22'd117304;
         5'd6:    atan_entry = 22'd58666;
         5'd7:    atan_entry = 22'd29335;
         5'd8:    atan_entry = 22'd14668;
         5'd9:    atan_entry = 22'd7334;
         5'd10:   atan_entry = 22'd3667;
         5'd11:   atan_entry = 22'd1833;
         5'd12:   atan_entry = 22'd917;
         5'd13:   atan_entry = 22'd458;
         5'd14:   atan_entry = 22'd229;
         5'd15:   atan_entry = 22'd115;
         5'd16:   atan_entry = 22'd57;
         5'd17:   atan_entry = 22'd29;
         5'd18:   atan_entry = 22'd14;
         5'd19:   atan_entry = 22'd7;
         5'd20:   atan_entry = 22'd4;
         5'd21:   atan_entry = 22'd2;
         5'd22:   atan_entry = 22'd1;
         default: atan_entry = 22'd0;
      endcase
   endfunction

endpackage

@@ hw/rtl/wpla_accum.sv @@
module wpla_accum
   import wpla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic       clear,
   input  req_type    pixel,
   input  cfg_type    cfg,
   output moment_type meas_mom,
   output moment_type cal_mom
);

   moment_type meas_ff, meas_in, cal_ff, cal_in;

   logic [ROI_SIDE_W-1:0]  eff_w, eff_h;
   logic [FRAME_CFG_W-1:0] eff_fw, eff_fh;
   logic [POS_W-1:0]       dx, dy;
   logic                   in_region, meas_white, cal_white;
   logic [COORD_W-1:0]     x, y;
   logic [SQ_W-1:0]        xx, yy, xy;

   // Region and frame containment
   always_comb begin
      eff_w  = sat_roi(cfg.roi_width);
      eff_h  = sat_roi(cfg.roi_height);
      eff_fw = sat_frame(cfg.frame_width);
      eff_fh = sat_frame(cfg.frame_height);
      dx = pixel.col - cfg.roi_left;
      dy = pixel.row - cfg.roi_top;
      in_region = (pixel.col >= cfg.roi_left) && (dx < POS_W'(eff_w)) &&
                  (pixel.row >= cfg.roi_top) && (dy < POS_W'(eff_h)) &&
                  (FRAME_CFG_W'(pixel.col) < eff_fw) && (FRAME_CFG_W'(pixel.row) < eff_fh);
      x  = dx[COORD_W-1:0];
      y  = dy[COORD_W-1:0];
      xx = SQ_W'({{COORD_W{1'b0}}, x} * {{COORD_W{1'b0}}, x});
      yy = SQ_W'({{COORD_W{1'b0}}, y} * {{COORD_W{1'b0}}, y});
      xy = SQ_W'({{COORD_W{1'b0}}, x} * {{COORD_W{1'b0}}, y});
      meas_white = (pixel.blue >= cfg.measure_level) && (pixel.green >= cfg.measure_level) &&
                   (pixel.red >= cfg.measure_level);
      cal_white  = pixel.calibrate && (pixel.blue >= cfg.calib_level) &&
                   (pixel.green >= cfg.calib_level) && (pixel.red >= cfg.calib_level);
   end

   // Add a white pixel to each set until its count saturates
   always_comb begin
      meas_in = meas_ff;
      cal_in  = cal_ff;
      if (clear) begin
         meas_in = '0;
         cal_in  = '0;
      end else if (enable && in_region) begin
         if (meas_white && (meas_ff.count < MAX_COUNT)) begin
            meas_in.count  = meas_ff.count + COUNT_W'(1);
            meas_in.sum_x  = meas_ff.sum_x + SUM_W'(x);
            meas_in.sum_y  = meas_ff.sum_y + SUM_W'(y);
            meas_in.sum_xx = meas_ff.sum_xx + xx;
            meas_in.sum_yy = meas_ff.sum_yy + yy;
            meas_in.sum_xy = meas_ff.sum_xy + xy;
         end
         if (cal_white && (cal_ff.count < MAX_COUNT)) begin
            cal_in.count  = cal_ff.count + COUNT_W'(1);
            cal_in.sum_x  = cal_ff.sum_x + SUM_W'(x);
            cal_in.sum_y  = cal_ff.sum_y + SUM_W'(y);
            cal_in.sum_xx = cal_ff.sum_xx + xx;
            cal_in.sum_yy = cal_ff.sum_yy + yy;
            cal_in.sum_xy = cal_ff.sum_xy + xy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_ff <= '0;
         cal_ff  <= '0;
      end else begin
         meas_ff <= meas_in;
         cal_ff  <= cal_in;
      end
   end

   assign meas_mom = meas_ff;
   assign cal_mom  = cal_ff;

endmodule

@@ hw/rtl/wpla_fit.sv @@
module wpla_fit
   import wpla_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  moment_type                mom,
   output logic                      done,
   output logic signed [ANGLE_W-1:0] angle
);

   typedef enum logic [6:0] {
      F_IDLE  = 7'b0000001,
      F_MUL   = 7'b0000010,
      F_ABS   = 7'b0000100,
      F_NORM  = 7'b0001000,
      F_FLIP  = 7'b0010000,
      F_ROT   = 7'b0100000,
      F_ROUND = 7'b1000000
   } fit_state_type;

   localparam logic [3:0] OP_LAST = 4'd8;
   localparam logic [ACC_W-1:0] NORM_HIGH = ACC_W'(64'd1 << 30);
   localparam logic [ACC_W-1:0] NORM_LOW  = ACC_W'(64'd1 << 29);
   localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);
   localparam logic signed [ANGLE_W:0] LIM_POS = (ANGLE_W+1)'(ANGLE_LIMIT);
   localparam logic signed [ANGLE_W:0] LIM_NEG = -(ANGLE_W+1)'(ANGLE_LIMIT);

   fit_state_type state_ff, state_in;
   logic [3:0]               op_ff, op_in;
   logic                     phase_ff, phase_in;
   logic [2*MUL_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]  xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic [ACC_W-1:0]         m_ff, m_in;
   logic signed [ROT_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic                     done_ff, done_in;

   logic [MUL_W-1:0]         mul_a, mul_b;
   logic                     term_neg, term_shift, term_to_y;
   logic signed [ACC_W-1:0]  term, ydbl;
   logic [ACC_W-1:0]         ax, ay;
   logic signed [ROT_W-1:0]  xs, ys;
   logic signed [Z_W-1:0]    atan_z, zr;
   logic signed [ANGLE_W:0]  neg_q;

   // Operand select for the shared multiplier; x gathers varx - vary, y gathers covxy
   always_comb begin
      mul_a = MUL_W'(mom.count);
      mul_b = '0;
      term_neg = 1'b0;
      term_shift = 1'b0;
      term_to_y = 1'b0;
      case (op_ff)
         4'd0: mul_b = MUL_W'(mom.sum_xx[SQ_LO_W-1:0]);
         4'd1: begin
            mul_b = MUL_W'(mom.sum_xx[SQ_W-1:SQ_LO_W]);
            term_shift = 1'b1;
         end
         4'd2: begin
            mul_a = MUL_W'(mom.sum_x);
            mul_b = MUL_W'(mom.sum_x);
            term_neg = 1'b1;
         end
         4'd3: begin
            mul_b = MUL_W'(mom.sum_yy[SQ_LO_W-1:0]);
            term_neg = 1'b1;
         end
         4'd4: begin
            mul_b = MUL_W'(mom.sum_yy[SQ_W-1:SQ_LO_W]);
            term_neg = 1'b1;
            term_shift = 1'b1;
         end
         4'd5: begin
            mul_a = MUL_W'(mom.sum_y);
            mul_b = MUL_W'(mom.sum_y);
         end
         4'd6: begin
            mul_b = MUL_W'(mom.sum_xy[SQ_LO_W-1:0]);
            term_to_y = 1'b1;
         end
         4'd7: begin
            mul_b = MUL_W'(mom.sum_xy[SQ_W-1:SQ_LO_W]);
            term_shift = 1'b1;
            term_to_y = 1'b1;
         end
         default: begin
            mul_a = MUL_W'(mom.sum_x);
            mul_b = MUL_W'(mom.sum_y);
            term_neg = 1'b1;
            term_to_y = 1'b1;
         end
      endcase
      prod_in = mul_a * mul_b;
      term = $signed({{(ACC_W-2*MUL_W){1'b0}}, prod_ff});
      if (term_shift) begin
         term = term <<< SQ_LO_W;
      end
   end

   // Shared datapath helpers
   always_comb begin
      ydbl = yacc_ff <<< 1;
      ax = xacc_ff[ACC_W-1] ? ACC_W'(-xacc_ff) : ACC_W'(xacc_ff);
      ay = ydbl[ACC_W-1] ? ACC_W'(-ydbl) : ACC_W'(ydbl);
      xs = rx_ff >>> step_ff;
      ys = ry_ff >>> step_ff;
      atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, atan_entry(step_ff)});
      zr = z_ff + Z_W'(256);
      neg_q = -{zr[Z_W-1], zr[Z_W-1:9]};
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      phase_in = phase_ff;
      xacc_in = xacc_ff;
      yacc_in = yacc_ff;
      m_in = m_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      z_in = z_ff;
      step_in = step_ff;
      angle_in = angle_ff;
      done_in = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               op_in = '0;
               phase_in = 1'b0;
               xacc_in = '0;
               yacc_in = '0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // Multiply on one cycle, accumulate on the next
            phase_in = ~phase_ff;
            if (phase_ff) begin
               if (term_to_y) begin
                  yacc_in = term_neg ? yacc_ff - term : yacc_ff + term;
               end else begin
                  xacc_in = term_neg ? xacc_ff - term : xacc_ff + term;
               end
               if (op_ff == OP_LAST) begin
                  state_in = F_ABS;
               end else begin
                  op_in = op_ff + 4'd1;
               end
            end
         end
         F_ABS: begin
            yacc_in = ydbl;
            m_in = (ax > ay) ? ax : ay;
            if ((xacc_ff == '0) && (ydbl == '0)) begin
               z_in = '0;
               state_in = F_ROUND;
            end else begin
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            // One bit of normalisation a cycle
            if (m_ff >= NORM_HIGH) begin
               xacc_in = xacc_ff >>> 1;
               yacc_in = yacc_ff >>> 1;
               m_in = m_ff >> 1;
            end else if (m_ff < NORM_LOW) begin
               xacc_in = xacc_ff <<< 1;
               yacc_in = yacc_ff <<< 1;
               m_in = m_ff << 1;
            end else begin
               state_in = F_FLIP;
            end
         end
         F_FLIP: begin
            step_in = '0;
            if (xacc_ff[ACC_W-1]) begin
               z_in = yacc_ff[ACC_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
               rx_in = -ROT_W'(xacc_ff);
               ry_in = -ROT_W'(yacc_ff);
            end else begin
               z_in = '0;
               rx_in = ROT_W'(xacc_ff);
               ry_in = ROT_W'(yacc_ff);
            end
            state_in = F_ROT;
         end
         F_ROT: begin
            // One vectoring rotation a cycle
            if (!ry_ff[ROT_W-1]) begin
               rx_in = rx_ff + ys;
               ry_in = ry_ff - xs;
               z_in = z_ff + atan_z;
            end else begin
               rx_in = rx_ff - ys;
               ry_in = ry_ff + xs;
               z_in = z_ff - atan_z;
            end
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = F_ROUND;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         F_ROUND: begin
            // Halve, round to 1/256 degree, negate and clamp
            if (neg_q > LIM_POS) begin
               angle_in = ANGLE_W'(LIM_POS);
            end else if (neg_q < LIM_NEG) begin
               angle_in = ANGLE_W'(LIM_NEG);
            end else begin
               angle_in = ANGLE_W'(neg_q);
            end
            done_in = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      phase_ff <= phase_in;
      prod_ff <= prod_in;
      xacc_ff <= xacc_in;
      yacc_ff <= yacc_in;
      m_ff <= m_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      z_ff <= z_in;
      step_ff <= step_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

@@ hw/rtl/white_pixel_line_angle.sv @@
// White-pixel line angle. Pixels stream in at one request per cycle while the frame
// is gathered; the frame-end request stalls the input while one shared fit unit
// (a single 30x30 multiplier, a one-bit normaliser and a CORDIC rotator) runs once
// for the calibration set when the baseline is renewed and once for the measurement
// set when it is not empty and the region lies inside the frame. Each fit runs its
// multiply/accumulate steps, then normalisation and rotation (both skipped when
// there is no spread), then sign, rounding and hand-over. Other pixels are taken
// one per cycle.
module white_pixel_line_angle
   import wpla_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_START  = 6'b000010,
      ST_CAL    = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_MEAS   = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   localparam logic signed [ANGLE_W:0] BEND_POS = (ANGLE_W+1)'(BEND_LIMIT);
   localparam logic signed [ANGLE_W:0] BEND_NEG = -(ANGLE_W+1)'(BEND_LIMIT);

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   logic      cal_fe_ff, cal_fe_in;
   logic      sel_cal_ff, sel_cal_in;
   logic signed [ANGLE_W-1:0] baseline_ff, baseline_in;
   logic signed [BEND_W-1:0]  last_bend_ff, last_bend_in;
   status_type status_ff, status_in;

   logic          accept, acc_clear, fit_start, fit_done, outside;
   logic signed [ANGLE_W-1:0] fit_angle;
   logic signed [ANGLE_W:0]   diff;
   moment_type    meas_mom, cal_mom, fit_mom;
   csr_index_type csr_index;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_index = csr_index_type'(paddr[4:2]);
   assign pready    = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (csr_index)
            REG_ROI_LEFT:      cfg_in.roi_left      = pwdata[POS_W-1:0];
            REG_ROI_TOP:       cfg_in.roi_top       = pwdata[POS_W-1:0];
            REG_ROI_WIDTH:     cfg_in.roi_width     = pwdata[ROI_SIDE_W-1:0];
            REG_ROI_HEIGHT:    cfg_in.roi_height    = pwdata[ROI_SIDE_W-1:0];
            REG_CALIB_LEVEL:   cfg_in.calib_level   = pwdata[LEVEL_W-1:0];
            REG_MEASURE_LEVEL: cfg_in.measure_level = pwdata[LEVEL_W-1:0];
            REG_FRAME_WIDTH:   cfg_in.frame_width   = pwdata[FRAME_CFG_W-1:0];
            REG_FRAME_HEIGHT:  cfg_in.frame_height  = pwdata[FRAME_CFG_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         REG_ROI_LEFT:      prdata = DATA_W'(cfg_ff.roi_left);
         REG_ROI_TOP:       prdata = DATA_W'(cfg_ff.roi_top);
         REG_ROI_WIDTH:     prdata = DATA_W'(cfg_ff.roi_width);
         REG_ROI_HEIGHT:    prdata = DATA_W'(cfg_ff.roi_height);
         REG_CALIB_LEVEL:   prdata = DATA_W'(cfg_ff.calib_level);
         REG_MEASURE_LEVEL: prdata = DATA_W'(cfg_ff.measure_level);
         REG_FRAME_WIDTH:   prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:  prdata = DATA_W'(cfg_ff.frame_height);
         default:           prdata = '0;
      endcase
   end

   wpla_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .enable   (accept),
      .clear    (acc_clear),
      .pixel    (req_data),
      .cfg      (cfg_ff),
      .meas_mom (meas_mom),
      .cal_mom  (cal_mom)
   );

   assign fit_mom = sel_cal_ff ? cal_mom : meas_mom;

   wpla_fit u_fit (
      .clock (clock),
      .reset (reset),
      .start (fit_start),
      .mom   (fit_mom),
      .done  (fit_done),
      .angle (fit_angle)
   );

   // Region must lie wholly inside the frame
   assign outside =
      ((FRAME_CFG_W'(cfg_ff.roi_left) + FRAME_CFG_W'(sat_roi(cfg_ff.roi_width))) >
       sat_frame(cfg_ff.frame_width)) ||
      ((FRAME_CFG_W'(cfg_ff.roi_top) + FRAME_CFG_W'(sat_roi(cfg_ff.roi_height))) >
       sat_frame(cfg_ff.frame_height));

   assign diff = {fit_angle[ANGLE_W-1], fit_angle} - {baseline_ff[ANGLE_W-1], baseline_ff};

   // Frame-end sequencer
   always_comb begin
      state_in = state_ff;
      cal_fe_in = cal_fe_ff;
      sel_cal_in = sel_cal_ff;
      baseline_in = baseline_ff;
      last_bend_in = last_bend_ff;
      status_in = status_ff;
      fit_start = 1'b0;
      acc_clear = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.frame_end) begin
               cal_fe_in = req_data.calibrate;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (cal_fe_ff && (cal_mom.count != '0)) begin
               sel_cal_in = 1'b1;
               fit_start = 1'b1;
               state_in = ST_CAL;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_CAL: begin
            if (fit_done) begin
               baseline_in = fit_angle;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (outside) begin
               status_in = STATUS_OUTSIDE;
               state_in = ST_RESP;
            end else if (meas_mom.count == '0) begin
               status_in = STATUS_EMPTY;
               state_in = ST_RESP;
            end else begin
               sel_cal_in = 1'b0;
               fit_start = 1'b1;
               state_in = ST_MEAS;
            end
         end
         ST_MEAS: begin
            if (fit_done) begin
               if (diff > BEND_POS) begin
                  last_bend_in = BEND_W'(BEND_POS);
               end else if (diff < BEND_NEG) begin
                  last_bend_in = BEND_W'(BEND_NEG);
               end else begin
                  last_bend_in = BEND_W'(diff);
               end
               status_in = STATUS_UPDATED;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // Hold the result until taken, then drop the frame's moments
            if (!rsp_stall) begin
               acc_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff.roi_left <= POS_W'(50);
         cfg_ff.roi_top <= POS_W'(200);
         cfg_ff.roi_width <= ROI_SIDE_W'(250);
         cfg_ff.roi_height <= ROI_SIDE_W'(320);
         cfg_ff.calib_level <= LEVEL_W'(200);
         cfg_ff.measure_level <= LEVEL_W'(180);
         cfg_ff.frame_width <= FRAME_CFG_W'(640);
         cfg_ff.frame_height <= FRAME_CFG_W'(480);
         baseline_ff <= '0;
         last_bend_ff <= '0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         baseline_ff <= baseline_in;
         last_bend_ff <= last_bend_in;
      end
   end

   always_ff @(posedge clock) begin
      cal_fe_ff <= cal_fe_in;
      sel_cal_ff <= sel_cal_in;
      status_ff <= status_in;
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data.bend_angle = last_bend_ff;
   assign rsp_data.baseline_angle_out = baseline_ff[15:0];
   assign rsp_data.status = status_ff;

endmodule

@@ hw/rtl/wpla_checker.sv @@
module wpla_checker
   import wpla_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A taken frame-end request raises the request stall
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_end |=> req_stall)
      else $error("request taken during fit");

   // No request is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with result pending");

   // Angles stay inside their clamps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.bend_angle) <= BEND_LIMIT) &&
                    ($signed(rsp_data.bend_angle) >= -BEND_LIMIT) &&
                    ($signed(rsp_data.baseline_angle_out) <= ANGLE_LIMIT) &&
                    ($signed(rsp_data.baseline_angle_out) >= -ANGLE_LIMIT))
      else $error("angle out of range");

endmodule

bind white_pixel_line_angle wpla_checker u_wpla_checker (.*);
